// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/segx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_pkg
// Types and constants for the 2-D segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int COORD_W      = 16;
  localparam int FRAC_W       = 16;
  localparam int THR_W        = 34;
  localparam int HIT_W        = 24;
  localparam int PARAM_W      = 17;
  localparam int STATUS_W     = 2;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
  } seg_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [HIT_W-1:0] hit_x;
    logic signed [HIT_W-1:0] hit_y;
    logic [PARAM_W-1:0]      param_first;
    logic [PARAM_W-1:0]      param_second;
  } seg_out_t;

endpackage

// ----- sv/segment_intersection_2d_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_top
// Intersection of two 2-D segments, fully pipelined, one pair per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_stall/in_data carries one segment pair per item.
//  Output channel out_valid/out_stall/out_data carries one result per item.
//  cfg_valid/cfg_ready/cfg_data writes parallel_threshold (34 bits, reset 1);
//  write it only while no item is in flight.
//  Throughput: one item per cycle while the output is not stalled; the
//  restoring divider is unrolled one quotient bit per pipeline stage, two
//  dividers side by side.
//  Stall: a stall on the output holds the whole pipeline; in_stall is high
//  whenever the last stage is full and stalled, so no item is lost.
//  Reset: synchronous active-low rst_n empties the pipeline and sets the
//  threshold to 1.
// ----------------------------------------------------------------------------
module segment_intersection_2d_top #(
  parameter int FRAC_BITS = segx_pkg::FRAC_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  segx_pkg::seg_in_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output segx_pkg::seg_out_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [segx_pkg::THR_W-1:0]     cfg_data
);
  import segx_pkg::*;

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;        // difference width
  localparam int PW   = 2 * DW + 1;    // cross product width
  localparam int MW   = PW;            // magnitude width
  localparam int NDIV = FRAC_BITS;
  localparam int NST  = NDIV + 5;      // register stages after input

  // pipeline advance: whole pipe moves unless the last stage is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  // threshold register
  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  logic [NST-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---- stage 1: differences
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, wx_r, wy_r;
  logic signed [CW-1:0] s1x_r, s1y_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= DW'(in_data.first_end_x) - DW'(in_data.first_start_x);
      dy1_r <= DW'(in_data.first_end_y) - DW'(in_data.first_start_y);
      dx2_r <= DW'(in_data.second_end_x) - DW'(in_data.second_start_x);
      dy2_r <= DW'(in_data.second_end_y) - DW'(in_data.second_start_y);
      wx_r  <= DW'(in_data.second_start_x) - DW'(in_data.first_start_x);
      wy_r  <= DW'(in_data.second_start_y) - DW'(in_data.first_start_y);
      s1x_r <= in_data.first_start_x;
      s1y_r <= in_data.first_start_y;
    end
  end

  // ---- stage 2: products
  logic signed [2*DW-1:0] p_r [6];
  logic signed [DW-1:0]   dx1_2_r, dy1_2_r;
  logic signed [CW-1:0]   s1x_2_r, s1y_2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= dx1_r * dy2_r;
      p_r[1] <= dy1_r * dx2_r;
      p_r[2] <= wx_r * dy2_r;
      p_r[3] <= wy_r * dx2_r;
      p_r[4] <= wx_r * dy1_r;
      p_r[5] <= wy_r * dx1_r;
      dx1_2_r <= dx1_r; dy1_2_r <= dy1_r;
      s1x_2_r <= s1x_r; s1y_2_r <= s1y_r;
    end
  end

  // ---- stage 3: cross differences, magnitudes, classification
  logic signed [PW-1:0] det_c, n1_c, n2_c;
  logic [MW-1:0] dm_c, n1m_c, n2m_c;
  logic par_c, out_c;
  always_comb begin
    det_c = PW'(p_r[0]) - PW'(p_r[1]);
    n1_c  = PW'(p_r[2]) - PW'(p_r[3]);
    n2_c  = PW'(p_r[4]) - PW'(p_r[5]);
    dm_c  = det_c[PW-1] ? MW'(-det_c) : MW'(det_c);
    n1m_c = n1_c[PW-1] ? MW'(-n1_c) : MW'(n1_c);
    n2m_c = n2_c[PW-1] ? MW'(-n2_c) : MW'(n2_c);
    // zero determinant is parallel whatever the threshold
    par_c = (dm_c == '0) || (MW'(thr_r) > dm_c);
    out_c = ((n1m_c != '0) && (n1_c[PW-1] != det_c[PW-1])) || (n1m_c > dm_c) ||
            ((n2m_c != '0) && (n2_c[PW-1] != det_c[PW-1])) || (n2m_c > dm_c);
  end

  // divider lanes: index 0 = stage 3 output, k = after k quotient bits
  logic [MW-1:0]        dv_r  [NDIV+1];
  logic [MW:0]          r1_r  [NDIV+1];
  logic [MW:0]          r2_r  [NDIV+1];
  logic [FRAC_BITS:0]   q1_r  [NDIV+1];
  logic [FRAC_BITS:0]   q2_r  [NDIV+1];
  logic [STATUS_W-1:0]  st_r  [NDIV+1];
  logic signed [DW-1:0] ddx_r [NDIV+1];
  logic signed [DW-1:0] ddy_r [NDIV+1];
  logic signed [CW-1:0] bsx_r [NDIV+1];
  logic signed [CW-1:0] bsy_r [NDIV+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]  <= dm_c;
      r1_r[0]  <= {1'b0, n1m_c};
      r2_r[0]  <= {1'b0, n2m_c};
      // a parameter of exactly 1 skips the loop as full scale
      q1_r[0]  <= (n1m_c >= dm_c) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
      q2_r[0]  <= (n2m_c >= dm_c) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
      st_r[0]  <= par_c ? ST_PARALLEL : (out_c ? ST_OUTSIDE : ST_HIT);
      ddx_r[0] <= dx1_2_r; ddy_r[0] <= dy1_2_r;
      bsx_r[0] <= s1x_2_r; bsy_r[0] <= s1y_2_r;
    end
  end

  // one restoring quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [MW+1:0] t1, t2;
    logic          full1, full2;
    assign full1 = q1_r[k][FRAC_BITS];
    assign full2 = q2_r[k][FRAC_BITS];
    assign t1 = {r1_r[k], 1'b0};
    assign t2 = {r2_r[k], 1'b0};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= dv_r[k];
        if (!full1 && t1 >= {2'b00, dv_r[k]}) begin
          r1_r[k+1] <= (MW+1)'(t1 - {2'b00, dv_r[k]});
          q1_r[k+1] <= {q1_r[k][FRAC_BITS-1:0], 1'b1};
        end else begin
          r1_r[k+1] <= (MW+1)'(t1);
          q1_r[k+1] <= full1 ? q1_r[k] : {q1_r[k][FRAC_BITS-1:0], 1'b0};
        end
        if (!full2 && t2 >= {2'b00, dv_r[k]}) begin
          r2_r[k+1] <= (MW+1)'(t2 - {2'b00, dv_r[k]});
          q2_r[k+1] <= {q2_r[k][FRAC_BITS-1:0], 1'b1};
        end else begin
          r2_r[k+1] <= (MW+1)'(t2);
          q2_r[k+1] <= full2 ? q2_r[k] : {q2_r[k][FRAC_BITS-1:0], 1'b0};
        end
        st_r[k+1]  <= st_r[k];
        ddx_r[k+1] <= ddx_r[k]; ddy_r[k+1] <= ddy_r[k];
        bsx_r[k+1] <= bsx_r[k]; bsy_r[k+1] <= bsy_r[k];
      end
    end
  end

  // ---- scale stage: q * |d|
  localparam int SW = FRAC_BITS + 1 + DW;
  logic [SW-1:0] sx_r, sy_r;
  logic nx_r, ny_r;
  logic [FRAC_BITS:0] qa_r, qb_r;
  logic [STATUS_W-1:0] stm_r;
  logic signed [CW-1:0] bx_r, by_r;
  logic [DW-1:0] mx_c, my_c;
  assign mx_c = ddx_r[NDIV][DW-1] ? DW'(-ddx_r[NDIV]) : DW'(ddx_r[NDIV]);
  assign my_c = ddy_r[NDIV][DW-1] ? DW'(-ddy_r[NDIV]) : DW'(ddy_r[NDIV]);
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= SW'(q1_r[NDIV]) * SW'(mx_c);
      sy_r  <= SW'(q1_r[NDIV]) * SW'(my_c);
      nx_r  <= ddx_r[NDIV][DW-1];
      ny_r  <= ddy_r[NDIV][DW-1];
      qa_r  <= q1_r[NDIV];
      qb_r  <= q2_r[NDIV];
      stm_r <= st_r[NDIV];
      bx_r  <= bsx_r[NDIV];
      by_r  <= bsy_r[NDIV];
    end
  end

  // ---- output stage
  logic [HIT_W-1:0] hx_c, hy_c, bxs_c, bys_c, stx_c, sty_c;
  logic hit_c;
  always_comb begin
    hit_c = (stm_r == ST_HIT);
    bxs_c = HIT_W'({{(HIT_W){bx_r[CW-1]}}, bx_r, 8'h00});
    bys_c = HIT_W'({{(HIT_W){by_r[CW-1]}}, by_r, 8'h00});
    stx_c = HIT_W'(sx_r >> (FRAC_BITS - 8));
    sty_c = HIT_W'(sy_r >> (FRAC_BITS - 8));
    hx_c  = nx_r ? bxs_c - stx_c : bxs_c + stx_c;
    hy_c  = ny_r ? bys_c - sty_c : bys_c + sty_c;
  end

  seg_out_t res_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.status       <= stm_r;
      res_r.hit_x        <= hit_c ? hx_c : '0;
      res_r.hit_y        <= hit_c ? hy_c : '0;
      res_r.param_first  <= hit_c ? PARAM_W'(qa_r) : '0;
      res_r.param_second <= hit_c ? PARAM_W'(qb_r) : '0;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = res_r;

endmodule

// ----- sv/segx_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segx_checker
// Port-level checks for the segment intersection block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input segx_pkg::seg_out_t out_data
);
  import segx_pkg::*;

  // held result stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, $stable(out_data) && out_valid, "output changed under stall")
  // input back-pressure only from a stalled full output
  `ASSERT_IMPL(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without cause")
  // non-hit results carry zero hit_x and zero parameters
  `ASSERT_IMPL(a_zero_miss, clk, rst_n, out_valid && out_data.status != ST_HIT, out_data.hit_x == '0 && out_data.param_first == '0 && out_data.param_second == '0, "miss carries data")
  // status code is in range
  `ASSERT_IMPL(a_status, clk, rst_n, out_valid, out_data.status == ST_HIT || out_data.status == ST_PARALLEL || out_data.status == ST_OUTSIDE, "bad status")

endmodule

bind segment_intersection_2d_top segx_checker u_segx_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_2d_top: drives segment pairs
// through random gaps and output stalls, predicts status, hit point and both
// segment parameters at the block's widths, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  import segx_pkg::*;

  localparam int LATENCY   = FRAC_W + 4;
  localparam int MAX_CYCLES = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  seg_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  seg_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [THR_W-1:0]   cfg_data = '0;

  logic [THR_W-1:0]   thr_model;
  seg_out_t           expected_q[$];
  int                 fail_count = 0;
  int                 result_count = 0;
  int                 hit_count = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 stall_enable = 1'b0;

  segment_intersection_2d_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL segment_intersection_2d_top");
      $finish;
    end
  end

  // 64-bit magnitude and sign, wrapping like the hardware would at width
  function automatic logic [63:0] mag64(input logic [63:0] v, output bit neg);
    neg = v[63];
    return neg ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] frac_quot(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = n;
    if (n >= d) return 64'd1 << FRAC_W;
    for (int i = 0; i < FRAC_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [HIT_W-1:0] point_coord(input longint st, input longint dl,
                                                    input logic [63:0] q);
    logic [63:0] base;
    logic [63:0] m;
    logic [63:0] stp;
    base = 64'(st) << 8;
    m = (dl < 0) ? 64'd0 - 64'(dl) : 64'(dl);
    stp = (q * m) >> (FRAC_W - 8);
    return (dl < 0) ? HIT_W'(base - stp) : HIT_W'(base + stp);
  endfunction

  // Predicts one result for a segment pair under the current threshold
  function automatic seg_out_t predict_intersection(input seg_in_t s);
    seg_out_t r;
    longint dx1, dy1, dx2, dy2, wx, wy;
    logic [63:0] dm, n1, n2, q1, q2;
    bit dn, n1n, n2n;
    r = '0;
    dx1 = longint'(s.first_end_x) - longint'(s.first_start_x);
    dy1 = longint'(s.first_end_y) - longint'(s.first_start_y);
    dx2 = longint'(s.second_end_x) - longint'(s.second_start_x);
    dy2 = longint'(s.second_end_y) - longint'(s.second_start_y);
    wx  = longint'(s.second_start_x) - longint'(s.first_start_x);
    wy  = longint'(s.second_start_y) - longint'(s.first_start_y);
    dm = mag64(64'(dx1 * dy2 - dy1 * dx2), dn);
    if (dm == 0 || dm < 64'(thr_model)) begin
      r.status = ST_PARALLEL;
      return r;
    end
    n1 = mag64(64'(wx * dy2 - wy * dx2), n1n);
    n2 = mag64(64'(wx * dy1 - wy * dx1), n2n);
    if ((n1 != 0 && n1n != dn) || n1 > dm || (n2 != 0 && n2n != dn) || n2 > dm) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    q1 = frac_quot(n1, dm);
    q2 = frac_quot(n2, dm);
    r.status = ST_HIT;
    r.hit_x = point_coord(longint'(s.first_start_x), dx1, q1);
    r.hit_y = point_coord(longint'(s.first_start_y), dy1, q1);
    r.param_first = PARAM_W'(q1);
    r.param_second = PARAM_W'(q2);
    return r;
  endfunction

  // Output stall pattern: mostly short bursts, occasionally long ones
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(8, 40))
                                                 : int'($urandom_range(0, 2));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    seg_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_q.size() == 0) begin
        $error("result with none expected: %p", out_data);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (e.status == ST_HIT) hit_count++;
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); fail_count++;
        end
        if (out_data.hit_x !== e.hit_x) begin
          $error("hit_x exp %0d got %0d", e.hit_x, out_data.hit_x); fail_count++;
        end
        if (out_data.hit_y !== e.hit_y) begin
          $error("hit_y exp %0d got %0d", e.hit_y, out_data.hit_y); fail_count++;
        end
        if (out_data.param_first !== e.param_first) begin
          $error("param_first exp %0d got %0d", e.param_first, out_data.param_first);
          fail_count++;
        end
        if (out_data.param_second !== e.param_second) begin
          $error("param_second exp %0d got %0d", e.param_second, out_data.param_second);
          fail_count++;
        end
      end
    end
  end

  // Sends one segment pair after a random gap, predicting at accept
  task automatic send_pair(input seg_in_t s);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    expected_q.insert(expected_q.size(), predict_intersection(s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  function automatic seg_in_t make_pair(input int a, b, c, d, e, f, g, h);
    seg_in_t s;
    s.first_start_x = COORD_W'(a); s.first_start_y = COORD_W'(b);
    s.first_end_x = COORD_W'(c); s.first_end_y = COORD_W'(d);
    s.second_start_x = COORD_W'(e); s.second_start_y = COORD_W'(f);
    s.second_end_x = COORD_W'(g); s.second_end_y = COORD_W'(h);
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(input int span);
    if (span == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, 2 * span) - span);
  endfunction

  // Random pair; often built to cross inside both segments
  function automatic seg_in_t rand_pair();
    seg_in_t s;
    int span, px, py;
    span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 14));
    s = {$urandom, $urandom, $urandom, $urandom};
    if (span != 0) begin
      s.first_start_x = rand_coord(span); s.first_start_y = rand_coord(span);
      s.first_end_x = rand_coord(span); s.first_end_y = rand_coord(span);
      s.second_start_x = rand_coord(span); s.second_start_y = rand_coord(span);
      if ($urandom_range(0, 1) == 0) begin
        // second segment passes through a point on the first, extended past it
        px = (int'(s.first_start_x) + int'(s.first_end_x)) / 2;
        py = (int'(s.first_start_y) + int'(s.first_end_y)) / 2;
        s.second_end_x = COORD_W'(2 * px - int'(s.second_start_x));
        s.second_end_y = COORD_W'(2 * py - int'(s.second_start_y));
      end else begin
        s.second_end_x = rand_coord(span); s.second_end_y = rand_coord(span);
      end
    end
    if ($urandom_range(0, 19) == 0) s.second_end_x = s.second_start_x + s.first_end_x
                                                    - s.first_start_x;
    return s;
  endfunction

  task automatic test_directed();
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));            // plain cross
    send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));              // parallel
    send_pair(make_pair(0, 0, 10, 0, 3, 0, 7, 0));               // collinear, det 0
    send_pair(make_pair(0, 0, 0, 0, 1, 1, 2, 2));                // degenerate point
    send_pair(make_pair(0, 0, 10, 0, 10, -5, 10, 5));            // hit at end, t1 = 1
    send_pair(make_pair(0, 0, 10, 0, 0, -5, 0, 5));              // hit at start
    send_pair(make_pair(0, 0, 10, 0, 11, -5, 11, 5));            // just past the end
    send_pair(make_pair(0, 0, 3, 0, -1, -1, 2, 2));              // lines cross at the start of the first
    send_pair(make_pair(0, 0, 3000, 1, 1, -1, 1, 100));          // slightly off, truncation
    send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 20));              // second misses
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    send_pair(make_pair(0, 0, 7, 3, 2, 5, 5, -4));
    drain();
  endtask

  task automatic test_thresholds();
    // zero threshold still flags zero det as parallel
    write_threshold('0);
    send_pair(make_pair(0, 0, 10, 0, 3, 0, 7, 0));
    send_pair(make_pair(0, 0, 1, 1, 0, 1, 1, 0));
    drain();
    write_threshold(THR_W'(3));
    send_pair(make_pair(0, 0, 1, 1, 0, 1, 1, 0));                // |det| 2, parallel
    send_pair(make_pair(0, 0, 2, 2, 0, 2, 2, 0));                // |det| 8, hit
    drain();
    write_threshold({THR_W{1'b1}});
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    drain();
    write_threshold(THR_W'(64'd8589934592));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_pair());
    drain();
  endtask

  initial begin
    thr_model = THR_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_enable = 1'b1;
    test_thresholds();
    write_threshold(THR_RESET);
    test_random(300);
    write_threshold(THR_W'($urandom_range(0, 5000)));
    test_random(200);
    stall_enable = 1'b0;
    write_threshold(THR_W'({$urandom, $urandom}));
    test_random(50);
    stall_enable = 1'b1;
    write_threshold(THR_W'(1));
    test_random(200);
    $display("Covered %0d results (%0d hits) over directed, threshold and random phases",
             result_count, hit_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("PASS segment_intersection_2d_top");
    end else begin
      $display("FAIL segment_intersection_2d_top");
    end
    $finish;
  end

endmodule
